### src/frustum_cull_test_defines.svh
// Assertion macros for the frustum cull test checker.
// No dependencies; included by the checker file.
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// Implication checked outside reset.
`define FCT_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("frustum cull check failed");

// Next-cycle implication, checked during reset as well.
`define FCT_ASSERT_NEXT(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("frustum cull check failed");

`endif

### src/fct_pkg.sv
// Shared constants and types for the frustum cull test block.
// No dependencies; used by frustum_cull_test and its checker.
`default_nettype none

package fct_pkg;

   localparam int COORD_BITS  = 24;
   localparam int PLANE_COUNT = 6;
   localparam int REG_COUNT   = 6;

   localparam int COEF_W  = 12;
   localparam int OFFS_W  = 28;
   localparam int OFFS_SH = 10;
   localparam int PLANE_W = 64;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_IDX_LO = 3;

   localparam int HALF_W     = COORD_BITS - 1;
   localparam int REQ_BITS   = 4 * COORD_BITS - 1;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   localparam int PROD_W   = COEF_W + COORD_BITS;
   localparam int ABSSUM_W = COEF_W + 2;
   localparam int HM_W     = HALF_W + ABSSUM_W;
   localparam int SUM_W    = (COORD_BITS + 15 > 40) ? COORD_BITS + 15 : 40;

   typedef logic signed [COEF_W-1:0]     coef_type;
   typedef logic signed [OFFS_W-1:0]     offs_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [HALF_W-1:0]     half_type;
   typedef logic        [PLANE_W-1:0]    plane_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic        [HM_W-1:0]       hm_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic        [CSR_IDX_W-1:0]  csr_idx_type;

   function automatic coef_type plane_a(input plane_type p);
      return coef_type'(p[COEF_W-1:0]);
   endfunction

   function automatic coef_type plane_b(input plane_type p);
      return coef_type'(p[2*COEF_W-1:COEF_W]);
   endfunction

   function automatic coef_type plane_c(input plane_type p);
      return coef_type'(p[3*COEF_W-1:2*COEF_W]);
   endfunction

   function automatic offs_type plane_d(input plane_type p);
      return offs_type'(p[PLANE_W-1:3*COEF_W]);
   endfunction

   // |a| fits COEF_W bits unsigned, including the most negative code
   function automatic logic [COEF_W-1:0] coef_abs(input coef_type v);
      return v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
   endfunction

endpackage

`default_nettype wire

### src/frustum_cull_test.sv
// Frustum cull test: four-stage pipeline testing points and cubes against planes.
// Depends on fct_pkg.
`default_nettype none
// Usage:
//   Write the six plane registers over the APB-style csr_ port (64-bit data,
//   register i at byte address 8*i; a = bits 11:0, b = 23:12, c = 35:24 as
//   Q1.10, d = bits 63:36 as Q19.8). Planes must be written while the block idles.
//   req_ channel: tuser = mode (0 point, 1 cube), tdata = centre x, y, z and
//   half size. One transfer gives exactly one rsp_ transfer with tdata bit 0
//   set when the object is inside or crosses the frustum.
//   A cube is culled when centre value + half_size*(|a|+|b|+|c|) is negative
//   for some plane, which is the largest of its eight corner values.
//   A request transfer passes the input, product, partial-sum and output registers
//   to rsp_tvalid; one item is taken every cycle unless rsp_tready backs it up.
//   Stall: a held rsp_tready stalls only the stages that are full; empty
//   stages still fill, so req_tready drops once all four stages hold items.
//   Reset (synchronous) clears the planes to zero, so every object is visible,
//   and empties the pipeline. The block does not check that planes are written only while it idles.

module frustum_cull_test (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fct_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fct_pkg::PLANE_W-1:0]       csr_pwdata,
   output logic [fct_pkg::PLANE_W-1:0]       csr_prdata,
   output logic                              csr_pready,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // fields from bit 0: center_x, center_y, center_z, half_size, zero pad
   input  logic [fct_pkg::REQ_DATA_W-1:0]    req_tdata,
   // fields from bit 0: mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // fields from bit 0: visible, zero pad
   output logic [fct_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int CB = fct_pkg::COORD_BITS;
   localparam int NP = fct_pkg::PLANE_COUNT;

   // ---------------- configuration ----------------
   fct_pkg::plane_type   plane_ff [fct_pkg::REG_COUNT];
   fct_pkg::csr_idx_type csr_idx;
   logic                 csr_wr;

   assign csr_idx    = csr_paddr[fct_pkg::CSR_IDX_LO +: fct_pkg::CSR_IDX_W];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < fct_pkg::REG_COUNT; r++) plane_ff[r] <= '0;
      end else if (csr_wr && (32'(csr_idx) < fct_pkg::REG_COUNT)) begin
         plane_ff[csr_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (32'(csr_idx) < fct_pkg::REG_COUNT) csr_prdata = plane_ff[csr_idx];
   end

   // planes tested; slots without a register are all zero and never cull
   fct_pkg::plane_type plane_w [NP];
   for (genvar g = 0; g < NP; g++) begin : g_plane
      if (g < fct_pkg::REG_COUNT) begin : g_reg
         assign plane_w[g] = plane_ff[g];
      end else begin : g_zero
         assign plane_w[g] = '0;
      end
   end

   // ---------------- stage enables ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic en1, en2, en3, en4;

   assign en4 = !s4_valid_ff || rsp_tready;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_tvalid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   logic                s1_mode_ff;
   fct_pkg::coord_type  s1_x_ff, s1_y_ff, s1_z_ff;
   fct_pkg::half_type   s1_h_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_mode_ff <= req_tuser;
         s1_x_ff    <= fct_pkg::coord_type'(req_tdata[CB-1:0]);
         s1_y_ff    <= fct_pkg::coord_type'(req_tdata[2*CB-1:CB]);
         s1_z_ff    <= fct_pkg::coord_type'(req_tdata[3*CB-1:2*CB]);
         s1_h_ff    <= req_tdata[3*CB +: fct_pkg::HALF_W];
      end
   end

   // ---------------- stage 2: products per plane ----------------
   fct_pkg::prod_type ax_in [NP], by_in [NP], cz_in [NP];
   fct_pkg::hm_type   hm_in [NP];
   fct_pkg::prod_type s2_ax_ff [NP], s2_by_ff [NP], s2_cz_ff [NP];
   fct_pkg::hm_type   s2_hm_ff [NP];

   for (genvar g = 0; g < NP; g++) begin : g_mul
      fct_pkg::coef_type             ca, cb, cc;
      logic [fct_pkg::ABSSUM_W-1:0]  abssum;

      assign ca = fct_pkg::plane_a(plane_w[g]);
      assign cb = fct_pkg::plane_b(plane_w[g]);
      assign cc = fct_pkg::plane_c(plane_w[g]);
      assign abssum = fct_pkg::ABSSUM_W'(fct_pkg::coef_abs(ca))
                    + fct_pkg::ABSSUM_W'(fct_pkg::coef_abs(cb))
                    + fct_pkg::ABSSUM_W'(fct_pkg::coef_abs(cc));

      assign ax_in[g] = ca * s1_x_ff;
      assign by_in[g] = cb * s1_y_ff;
      assign cz_in[g] = cc * s1_z_ff;
      // point mode tests the centre only
      assign hm_in[g] = s1_mode_ff
                      ? fct_pkg::HM_W'(s1_h_ff) * fct_pkg::HM_W'(abssum)
                      : '0;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int p = 0; p < NP; p++) begin
            s2_ax_ff[p] <= ax_in[p];
            s2_by_ff[p] <= by_in[p];
            s2_cz_ff[p] <= cz_in[p];
            s2_hm_ff[p] <= hm_in[p];
         end
      end
   end

   // ---------------- stage 3: partial sums ----------------
   fct_pkg::sum_type p0_in [NP], p1_in [NP];
   fct_pkg::sum_type s3_p0_ff [NP], s3_p1_ff [NP];

   for (genvar g = 0; g < NP; g++) begin : g_add
      logic signed [fct_pkg::OFFS_W+fct_pkg::OFFS_SH-1:0] dsh;
      logic signed [fct_pkg::HM_W:0]                      hm_s;

      // d carries 8 fraction bits, the products 18
      assign dsh  = {fct_pkg::plane_d(plane_w[g]), {fct_pkg::OFFS_SH{1'b0}}};
      assign hm_s = {1'b0, s2_hm_ff[g]};

      assign p0_in[g] = fct_pkg::sum_type'(s2_ax_ff[g]) + fct_pkg::sum_type'(s2_by_ff[g]);
      assign p1_in[g] = fct_pkg::sum_type'(s2_cz_ff[g]) + fct_pkg::sum_type'(dsh)
                      + fct_pkg::sum_type'(hm_s);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         for (int p = 0; p < NP; p++) begin
            s3_p0_ff[p] <= p0_in[p];
            s3_p1_ff[p] <= p1_in[p];
         end
      end
   end

   // ---------------- stage 4: sign test and output register ----------------
   logic [NP-1:0] neg;
   logic          visible_in, visible_ff;

   always_comb begin
      fct_pkg::sum_type total;
      for (int p = 0; p < NP; p++) begin
         total  = s3_p0_ff[p] + s3_p1_ff[p];
         neg[p] = total[fct_pkg::SUM_W-1];
      end
   end

   assign visible_in = ~|neg;

   always_ff @(posedge clock) begin
      if (en4) visible_ff <= visible_in;
   end

   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = {{(fct_pkg::RSP_DATA_W-1){1'b0}}, visible_ff};

endmodule

`default_nettype wire

### src/fct_checker.sv
// Port-level checker for frustum_cull_test, bound to the top level.
// Depends on fct_pkg and frustum_cull_test_defines.svh.
`default_nettype none
`include "frustum_cull_test_defines.svh"

module fct_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fct_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // pipeline empties on reset
   `FCT_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)

   // a result waiting on the receiver holds
   `FCT_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready ##1 !reset, rsp_tvalid && $stable(rsp_tdata))

   // a ready receiver never backs up the request side
   `FCT_ASSERT_IMPL(a_no_backpressure, clock, reset, rsp_tready, req_tready)

   // with no stall, a request transfer reaches rsp_tvalid through the stage registers
   `FCT_ASSERT_IMPL(a_latency, clock, reset, (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready ##1 1'b1, rsp_tvalid)

endmodule

bind frustum_cull_test fct_checker u_fct_checker (.*);

`default_nettype wire

### dv/frustum_cull_checker.sv
// Checker for the frustum cull block: tracks plane writes on the csr_ port,
// predicts the visible flag of every req_ transfer and compares rsp_ transfers.
// Depends on fct_pkg for widths and register count.
`timescale 1ns / 100ps

module frustum_cull_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fct_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fct_pkg::PLANE_W-1:0]     csr_pwdata,
   input  logic                            csr_pready,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // fields from bit 0: center_x, center_y, center_z, half_size, zero pad
   input  logic [fct_pkg::REQ_DATA_W-1:0]  req_tdata,
   // fields from bit 0: mode
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // fields from bit 0: visible, zero pad
   input  logic [fct_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output int                              mismatches,
   output int                              pending
);
   import fct_pkg::*;

   plane_type plane_copy [REG_COUNT];
   logic      visible_due [$];

   // Signed distance of (x, y, z) from plane p, scaled to 18 fraction bits.
   function automatic longint plane_distance(input plane_type p,
                                             input longint x, y, z);
      logic signed [COEF_W-1:0] a, b, c;
      logic signed [OFFS_W-1:0] d;
      a = p[COEF_W-1:0];
      b = p[2*COEF_W-1:COEF_W];
      c = p[3*COEF_W-1:2*COEF_W];
      d = p[PLANE_W-1:3*COEF_W];
      return a * x + b * y + c * z + longint'(d) * 1024;
   endfunction

   function automatic logic object_visible(input logic cube, input coord_type cx, cy, cz,
                                           input half_type h);
      longint xc, yc, zc, hl;
      logic   shown;
      logic   any_in;
      xc = cx;
      yc = cy;
      zc = cz;
      hl = h;
      shown = 1'b1;
      for (int i = 0; i < PLANE_COUNT; i++) begin
         // slots past the register file read as zero and never cull
         if (i < REG_COUNT) begin
            if (!cube) begin
               if (plane_distance(plane_copy[i], xc, yc, zc) < 0)
                  shown = 1'b0;
            end else begin
               any_in = 1'b0;
               for (int k = 0; k < 8; k++) begin
                  if (plane_distance(plane_copy[i],
                                     (k & 1) ? xc + hl : xc - hl,
                                     (k & 2) ? yc + hl : yc - hl,
                                     (k & 4) ? zc + hl : zc - hl) >= 0)
                     any_in = 1'b1;
               end
               if (!any_in)
                  shown = 1'b0;
            end
         end
      end
      return shown;
   endfunction

   always @(posedge clock) begin : watch
      logic        due;
      csr_idx_type slot;
      if (reset) begin
         foreach (plane_copy[i])
            plane_copy[i] = '0;
         visible_due.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            slot = csr_paddr[CSR_IDX_LO +: CSR_IDX_W];
            if (slot < REG_COUNT)
               plane_copy[slot] = csr_pwdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (visible_due.size() == 0) begin
               $display("%0t: rsp transfer with nothing outstanding, actual visible %0b",
                        $time, rsp_tdata[0]);
               mismatches++;
            end else begin
               due = visible_due.pop_front();
               if (rsp_tdata[0] !== due) begin
                  $display("%0t: visible mismatch, expected %0b actual %0b",
                           $time, due, rsp_tdata[0]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            visible_due.push_back(object_visible(req_tuser,
                                                 req_tdata[0 +: COORD_BITS],
                                                 req_tdata[COORD_BITS +: COORD_BITS],
                                                 req_tdata[2*COORD_BITS +: COORD_BITS],
                                                 req_tdata[3*COORD_BITS +: HALF_W]));
      end
      pending = visible_due.size();
   end

endmodule

### dv/tb_frustum_cull_test.sv
// Testbench top for frustum_cull_test: drives plane writes and object transfers,
// stalls the result side at random and reports the verdict.
// Depends on fct_pkg, frustum_cull_test and frustum_cull_checker.
`timescale 1ns / 100ps

module tb_frustum_cull_test;
   import fct_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 230;
   localparam int CALM_ITEMS    = 300;
   localparam int RANDOM_ITEMS  = PHASES * PHASE_ITEMS;
   localparam int SLOT_COUNT    = 8;

   localparam logic MODE_POINT = 1'b0;
   localparam logic MODE_CUBE  = 1'b1;

   localparam int IDX_NEAR   = 0;
   localparam int IDX_FAR    = 1;
   localparam int IDX_LEFT   = 2;
   localparam int IDX_RIGHT  = 3;
   localparam int IDX_TOP    = 4;
   localparam int IDX_BOTTOM = 5;

   localparam coord_type COORD_MIN = coord_type'(1 << (COORD_BITS - 1));
   localparam coord_type COORD_MAX = ~COORD_MIN;
   localparam half_type  HALF_MAX  = '1;
   localparam int        ONE       = 1024;      // 1.0 in Q1.10
   localparam int        UNIT      = 256;       // 1.0 in Q15.8

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [PLANE_W-1:0]      csr_pwdata  = '0;
   logic [PLANE_W-1:0]      csr_prdata;
   logic                    csr_pready;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   logic                    req_tuser   = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   int          mismatches;
   int          pending;
   int          stall_left = 0;
   logic        calm = 1'b0;
   int unsigned cycles = 0;

   frustum_cull_test DUT (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   frustum_cull_checker CHECK (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .mismatches(mismatches), .pending(pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic plane_type make_plane(input int a, b, c, d);
      return {OFFS_W'(d), COEF_W'(c), COEF_W'(b), COEF_W'(a)};
   endfunction

   function automatic plane_type pick_plane();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return {$urandom, $urandom};
         default: return make_plane(int'($urandom_range(0, 2 * ONE)) - ONE,
                                    int'($urandom_range(0, 2 * ONE)) - ONE,
                                    int'($urandom_range(0, 2 * ONE)) - ONE,
                                    int'($urandom_range(0, 120 * UNIT)) - 60 * UNIT);
      endcase
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 3))
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(0, 400 * UNIT)) - 200 * UNIT);
         2: case ($urandom_range(0, 4))
               0:       return COORD_MIN;
               1:       return COORD_MAX;
               2:       return coord_type'(1);
               3:       return coord_type'(-1);
               default: return '0;
            endcase
         default: return coord_type'(int'($urandom_range(0, 8192)) - 4096);
      endcase
   endfunction

   function automatic half_type pick_half();
      case ($urandom_range(0, 3))
         0:       return half_type'($urandom);
         1:       return half_type'($urandom_range(0, 64 * UNIT));
         2:       return '0;
         default: return HALF_MAX;
      endcase
   endfunction

   task automatic write_plane(input int idx, input plane_type value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one object transfer, with a random gap in front of it unless calm
   task automatic offer(input logic mode, input coord_type x, y, z, input half_type h);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_W'({h, z, y, x});
      do @(posedge clock); while (!req_tready);
   endtask

   // planes only change once every transfer has come back
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      int done;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero planes after reset: everything visible
      offer(MODE_POINT, COORD_MAX, COORD_MAX, COORD_MAX, '0);
      offer(MODE_POINT, COORD_MIN, COORD_MIN, COORD_MIN, HALF_MAX);
      offer(MODE_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, HALF_MAX);
      settle();

      // box 200 units wide and high, 100 deep, with the near plane at z = 0
      write_plane(IDX_NEAR,   make_plane(0, 0, ONE, 0));
      write_plane(IDX_FAR,    make_plane(0, 0, -ONE, 100 * UNIT));
      write_plane(IDX_LEFT,   make_plane(ONE, 0, 0, 100 * UNIT));
      write_plane(IDX_RIGHT,  make_plane(-ONE, 0, 0, 100 * UNIT));
      write_plane(IDX_TOP,    make_plane(0, -ONE, 0, 100 * UNIT));
      write_plane(IDX_BOTTOM, make_plane(0, ONE, 0, 100 * UNIT));
      offer(MODE_POINT, '0, '0, '0, '0);                  // on the plane, not below
      offer(MODE_POINT, '0, '0, coord_type'(-1), '0);
      offer(MODE_POINT, '0, '0, coord_type'(50 * UNIT), '0);
      offer(MODE_POINT, '0, '0, COORD_MAX, '0);
      offer(MODE_CUBE, '0, '0, coord_type'(-10 * UNIT), half_type'(10 * UNIT));
      offer(MODE_CUBE, '0, '0, coord_type'(-10 * UNIT), half_type'(10 * UNIT - 1));
      offer(MODE_CUBE, COORD_MAX, COORD_MAX, COORD_MAX, HALF_MAX);
      offer(MODE_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, '0);
      settle();

      // coefficient and offset extremes; slots 6 and 7 do not exist
      write_plane(IDX_NEAR,   '1);
      write_plane(IDX_FAR,    {1'b0, {(PLANE_W - 1){1'b1}}});
      write_plane(IDX_LEFT,   make_plane(-2 * ONE, -2 * ONE, -2 * ONE, 0));
      write_plane(IDX_RIGHT,  make_plane(2 * ONE - 1, 2 * ONE - 1, 2 * ONE - 1,
                                         -(1 << (OFFS_W - 1))));
      write_plane(IDX_TOP,    '0);
      write_plane(IDX_BOTTOM, '0);
      write_plane(REG_COUNT,  '1);
      write_plane(SLOT_COUNT - 1, '1);
      offer(MODE_POINT, COORD_MIN, COORD_MIN, COORD_MIN, '0);
      offer(MODE_POINT, COORD_MAX, COORD_MAX, COORD_MAX, '0);
      offer(MODE_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, HALF_MAX);
      offer(MODE_CUBE, COORD_MAX, COORD_MAX, COORD_MAX, HALF_MAX);
      offer(MODE_POINT, '0, '0, '0, HALF_MAX);
      offer(MODE_CUBE, '0, '0, '0, '0);
      settle();

      // most negative offset alone culls everything
      write_plane(IDX_NEAR, {1'b1, {(PLANE_W - 1){1'b0}}});
      offer(MODE_POINT, '0, '0, '0, '0);
      offer(MODE_CUBE, '0, '0, '0, HALF_MAX);
      settle();

      done = 0;
      for (int p = 0; p < PHASES; p++) begin
         for (int r = 0; r < REG_COUNT; r++)
            write_plane(r, pick_plane());
         write_plane($urandom_range(REG_COUNT, SLOT_COUNT - 1), {$urandom, $urandom});
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (done >= RANDOM_ITEMS - CALM_ITEMS)
               calm = 1'b1;
            offer(logic'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_coord(),
                  pick_half());
            done++;
         end
         settle();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
